// File: design/signed_count_rle_decoder_core_macros.svh
// ----------------------------------------------------------------------------
// signed_count_rle_decoder_core_macros
// Assertion macros shared by the decoder RTL.
// ----------------------------------------------------------------------------
`ifndef SIGNED_COUNT_RLE_DECODER_CORE_MACROS_SVH
`define SIGNED_COUNT_RLE_DECODER_CORE_MACROS_SVH

// Same-cycle implication, checked on clk while out of reset.
`define SCRLE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk while out of reset.
`define SCRLE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/scrle_pkg.sv
// ----------------------------------------------------------------------------
// scrle_pkg
// Types and constants for the signed-count run-length decoder.
// ----------------------------------------------------------------------------
package scrle_pkg;

	localparam int unsigned HDR_BYTES = 4;
	localparam int unsigned HDR_CNT_W = 3;
	localparam int unsigned SIZE_W    = 32;
	localparam int unsigned PROD_W    = SIZE_W + 1;

	typedef enum logic [1:0] {
		PH_CONTROL = 2'd0,
		PH_LITERAL = 2'd1,
		PH_REPEAT  = 2'd2
	} phase_t;

endpackage

// File: design/signed_count_rle_decoder_core.sv
// A result is registered and appears in the cycle after the transfer of the byte that causes it.
// Throughput: one byte per cycle; the output register frees the input side whenever
// the held result is taken, so the block stalls only while a result waits.
// Per-byte work is one 33-bit saturating add and compare with the declared size.
// Reset (arst_n low, asynchronous) clears header, phase, counters and the output valid.
// ----------------------------------------------------------------------------
// signed_count_rle_decoder_core
// Byte-wide signed-count run-length decoder: four-byte big-endian size header, then
// signed control bytes; emits value/count pairs and a sticky overflow flag.
// ----------------------------------------------------------------------------
`include "signed_count_rle_decoder_core_macros.svh"

module signed_count_rle_decoder_core
	import scrle_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        in_byte,
	input  logic              last_byte,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        value,
	output logic [7:0]        repeat_count,
	output logic [SIZE_W-1:0] declared_size,
	output logic              overflow
);

	logic [HDR_CNT_W-1:0] hdr_cnt_q;
	logic [SIZE_W-1:0]    size_q;
	phase_t               phase_q;
	logic [6:0]           lit_left_q;
	logic [7:0]           rep_cnt_q;
	logic [PROD_W-1:0]    prod_q;
	logic                 ovf_q;

	logic                 out_valid_q;
	logic [7:0]           value_q;
	logic [7:0]           count_q;
	logic [SIZE_W-1:0]    size_out_q;
	logic                 ovf_out_q;

	logic                 in_fire;
	logic                 emit;
	logic [7:0]           emit_cnt;
	logic [PROD_W:0]      prod_sum;
	logic [PROD_W-1:0]    prod_nxt;
	logic                 ovf_nxt;
	logic [HDR_CNT_W-1:0] hdr_cnt_nxt;
	logic [SIZE_W-1:0]    size_nxt;
	phase_t               phase_nxt;
	logic [6:0]           lit_left_nxt;
	logic [7:0]           rep_cnt_nxt;

	// hold off only while a finished result is still waiting
	assign in_stall = out_valid_q && out_stall;
	assign in_fire  = in_valid && !in_stall;

	always_comb begin
		emit         = 1'b0;
		emit_cnt     = 8'd1;
		hdr_cnt_nxt  = hdr_cnt_q;
		size_nxt     = size_q;
		phase_nxt    = phase_q;
		lit_left_nxt = lit_left_q;
		rep_cnt_nxt  = rep_cnt_q;
		if (hdr_cnt_q < HDR_CNT_W'(HDR_BYTES)) begin
			size_nxt    = {size_q[SIZE_W-9:0], in_byte};
			hdr_cnt_nxt = hdr_cnt_q + 1'b1;
		end else begin
			case (phase_q)
				PH_LITERAL: begin
					emit = 1'b1;
					if (lit_left_q != 7'd0)
						lit_left_nxt = lit_left_q - 1'b1;
					if (lit_left_nxt == 7'd0)
						phase_nxt = PH_CONTROL;
				end
				PH_REPEAT: begin
					emit        = 1'b1;
					emit_cnt    = rep_cnt_q;
					rep_cnt_nxt = 8'd0;
					phase_nxt   = PH_CONTROL;
				end
				default: begin
					phase_nxt = PH_CONTROL;
					if (in_byte == 8'd0) begin
						phase_nxt = PH_CONTROL;
					end else if (!in_byte[7]) begin
						lit_left_nxt = in_byte[6:0];
						phase_nxt    = PH_LITERAL;
					end else begin
						// two's complement negate; 0x80 gives 128
						rep_cnt_nxt = ~in_byte + 8'd1;
						phase_nxt   = PH_REPEAT;
					end
				end
			endcase
		end
	end

	// running decoded count saturates at all ones
	assign prod_sum = {1'b0, prod_q} + (PROD_W+1)'(emit_cnt);
	assign prod_nxt = prod_sum[PROD_W] ? {PROD_W{1'b1}} : prod_sum[PROD_W-1:0];
	assign ovf_nxt  = ovf_q || (prod_nxt > {1'b0, size_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_cnt_q   <= '0;
			size_q      <= '0;
			phase_q     <= PH_CONTROL;
			lit_left_q  <= '0;
			rep_cnt_q   <= '0;
			prod_q      <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire && emit)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			if (in_fire) begin
				if (last_byte) begin
					hdr_cnt_q  <= '0;
					size_q     <= '0;
					phase_q    <= PH_CONTROL;
					lit_left_q <= '0;
					rep_cnt_q  <= '0;
					prod_q     <= '0;
					ovf_q      <= 1'b0;
				end else begin
					hdr_cnt_q  <= hdr_cnt_nxt;
					size_q     <= size_nxt;
					phase_q    <= phase_nxt;
					lit_left_q <= lit_left_nxt;
					rep_cnt_q  <= rep_cnt_nxt;
					if (emit) begin
						prod_q <= prod_nxt;
						ovf_q  <= ovf_nxt;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && emit) begin
			value_q    <= in_byte;
			count_q    <= emit_cnt;
			size_out_q <= size_q;
			ovf_out_q  <= ovf_nxt;
		end
	end

	assign out_valid     = out_valid_q;
	assign value         = value_q;
	assign repeat_count  = count_q;
	assign declared_size = size_out_q;
	assign overflow      = ovf_out_q;

	`SCRLE_ASSERT_NOW(a_count_range, out_valid_q,
		(count_q != 8'd0) && (count_q <= 8'd128), "repeat count out of range")
	`SCRLE_ASSERT_NOW(a_literal_left, phase_q == PH_LITERAL,
		lit_left_q != 7'd0, "literal phase with nothing left")
	`SCRLE_ASSERT_NOW(a_stall_only_held, in_stall, out_valid_q,
		"input stalled with no result held")
	`SCRLE_ASSERT_NEXT(a_last_clears, in_fire && last_byte,
		(hdr_cnt_q == '0) && (phase_q == PH_CONTROL) && !ovf_q && (prod_q == '0),
		"state not cleared after last byte")

endmodule

// File: tb/signed_count_rle_decoder_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// signed_count_rle_decoder_core_test
// Drives encoded byte streams into the run-length decoder and checks every
// value/count pair, declared size and overflow flag against a local decoder
// model, under several mixes of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module signed_count_rle_decoder_core_test;
	import scrle_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 4;

	typedef struct {
		logic [7:0]        val;
		logic [7:0]        reps;
		logic [SIZE_W-1:0] decl;
		logic              ovf;
	} run_pair_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [7:0]        in_byte = 8'h00;
	logic              last_byte = 1'b0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [7:0]        value;
	logic [7:0]        repeat_count;
	logic [SIZE_W-1:0] declared_size;
	logic              overflow;

	// decoder model state
	int unsigned       hdr_taken = 0;
	logic [SIZE_W-1:0] size_acc = '0;
	phase_t            dec_phase = PH_CONTROL;
	logic [6:0]        lits_left = '0;
	logic [7:0]        rep_pending = '0;
	logic [PROD_W-1:0] produced = '0;
	logic              ovf_seen = 1'b0;

	run_pair_t         pending_runs[$];
	int                mismatches = 0;
	int                bytes_sent = 0;
	int                cycles = 0;
	int                sender_idle_pct = 0;
	int                receiver_stall_pct = 0;

	signed_count_rle_decoder_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.in_byte       (in_byte),
		.last_byte     (last_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.value         (value),
		.repeat_count  (repeat_count),
		.declared_size (declared_size),
		.overflow      (overflow)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("signed_count_rle_decoder_core: mismatch");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		$display("ERROR %0t: %s", $time, msg);
		mismatches++;
	endtask

	// Book a decoded run; produced count saturates at the 33-bit ceiling.
	function automatic void book_run(input logic [7:0] val, input logic [7:0] reps);
		logic [PROD_W:0] sum;
		run_pair_t       run;
		sum = {1'b0, produced} + reps;
		produced = sum[PROD_W] ? '1 : sum[PROD_W-1:0];
		if (produced > {1'b0, size_acc})
			ovf_seen = 1'b1;
		run.val = val;
		run.reps = reps;
		run.decl = size_acc;
		run.ovf = ovf_seen;
		pending_runs.push_back(run);
	endfunction

	function automatic void decode_byte(input logic [7:0] b, input logic last);
		if (hdr_taken < HDR_BYTES) begin
			size_acc = {size_acc[SIZE_W-9:0], b};
			hdr_taken++;
		end else if (dec_phase == PH_LITERAL) begin
			book_run(b, 8'd1);
			if (lits_left != 0)
				lits_left--;
			if (lits_left == 0)
				dec_phase = PH_CONTROL;
		end else if (dec_phase == PH_REPEAT) begin
			book_run(b, rep_pending);
			rep_pending = '0;
			dec_phase = PH_CONTROL;
		end else begin
			dec_phase = PH_CONTROL;
			if (b == 8'h00) begin
				// no-op control
			end else if (b < 8'h80) begin
				lits_left = b[6:0];
				dec_phase = PH_LITERAL;
			end else begin
				// negated count; 0x80 wraps to 128
				rep_pending = 8'd0 - b;
				dec_phase = PH_REPEAT;
			end
		end
		if (last) begin
			hdr_taken = 0;
			size_acc = '0;
			dec_phase = PH_CONTROL;
			lits_left = '0;
			rep_pending = '0;
			produced = '0;
			ovf_seen = 1'b0;
		end
	endfunction

	// Called just after a rising edge; returns just after the edge of the transfer.
	task automatic send_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			in_byte <= 8'($urandom);
			last_byte <= 1'($urandom_range(1));
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		last_byte <= last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		decode_byte(b, last);
		bytes_sent++;
	endtask

	always @(posedge clk) begin
		run_pair_t run;
		out_stall <= ($urandom_range(99) < receiver_stall_pct);
		if (arst_n && out_valid && !out_stall) begin
			if (pending_runs.size() == 0) begin
				report_mismatch($sformatf("unexpected result value %02h count %0d",
					value, repeat_count));
			end else begin
				run = pending_runs.pop_front();
				if (value !== run.val)
					report_mismatch($sformatf("value %02h, want %02h", value, run.val));
				if (repeat_count !== run.reps)
					report_mismatch($sformatf("repeat_count %0d, want %0d",
						repeat_count, run.reps));
				if (declared_size !== run.decl)
					report_mismatch($sformatf("declared_size %08h, want %08h",
						declared_size, run.decl));
				if (overflow !== run.ovf)
					report_mismatch($sformatf("overflow %b, want %b", overflow, run.ovf));
			end
		end
	end

	// size exactly met: no overflow; no-op control, literal extremes, single repeat
	task automatic test_literals_and_noop();
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h03, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h02, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h80, 1'b1);
	endtask

	// longest repeat, then a near-longest repeat cut off by the end of stream
	task automatic test_repeat_extremes();
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h7F, 1'b0);
		send_byte(8'h81, 1'b1);
	endtask

	// zero declared size: first literal overflows, flag holds; literal run cut off
	task automatic test_overflow_sticky();
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(8'h5A, 1'b0);
		send_byte(8'h7F, 1'b0);
		send_byte(8'hC3, 1'b1);
	endtask

	// stream ending inside its header
	task automatic test_header_cut_off();
		send_byte(8'h12, 1'b1);
	endtask

	// mostly well-formed streams with random content; some noise and truncation
	task automatic test_random_streams(input int idle_pct, input int stall_pct,
		input int n_bytes);
		logic [7:0]        stream[$];
		logic [SIZE_W-1:0] sz;
		int                first;
		int                cut;
		int                k;
		first = bytes_sent;
		sender_idle_pct = idle_pct;
		receiver_stall_pct = stall_pct;
		while (bytes_sent - first < n_bytes) begin
			stream.delete();
			if ($urandom_range(9) == 0) begin
				repeat ($urandom_range(1, 20))
					stream.push_back(8'($urandom));
			end else begin
				case ($urandom_range(3))
					0: sz = $urandom_range(0, 40);
					1: sz = $urandom_range(0, 600);
					2: sz = $urandom;
					default: sz = $urandom_range(1) ? '1 : '0;
				endcase
				for (int i = 3; i >= 0; i--)
					stream.push_back(sz[8*i +: 8]);
				repeat ($urandom_range(1, 10)) begin
					case ($urandom_range(9))
						0: stream.push_back(8'h00);
						1, 2, 3, 4: begin
							k = ($urandom_range(7) == 0) ? $urandom_range(1, 127)
								: $urandom_range(1, 6);
							stream.push_back(8'(k));
							repeat (k)
								stream.push_back(8'($urandom));
						end
						default: begin
							k = ($urandom_range(7) == 0) ? $urandom_range(120, 128)
								: $urandom_range(1, 128);
							stream.push_back(8'(256 - k));
							stream.push_back(8'($urandom));
						end
					endcase
				end
			end
			cut = stream.size() - 1;
			if ($urandom_range(6) == 0)
				cut = $urandom_range(0, stream.size() - 1);
			for (int i = 0; i <= cut; i++)
				send_byte(stream[i], i == cut);
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_literals_and_noop();
		test_repeat_extremes();
		test_overflow_sticky();
		test_header_cut_off();
		test_random_streams(0, 0, 240);
		test_random_streams(58, 0, 240);
		test_random_streams(0, 58, 240);
		test_random_streams(36, 36, 240);
		in_valid <= 1'b0;
		while (pending_runs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("signed_count_rle_decoder_core: match");
		else
			$display("signed_count_rle_decoder_core: mismatch");
		$finish;
	end

endmodule

// File: files.f
+incdir+design
design/scrle_pkg.sv
design/signed_count_rle_decoder_core.sv
tb/signed_count_rle_decoder_core_test.sv
